/* src/baro_sensor_compensation_assert.svh */
// Assertion macros shared by the compensation block.
`ifndef BARO_SENSOR_COMPENSATION_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define BSC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("bsc: forbidden condition seen");

`define BSC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bsc: implication failed");

`define BSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bsc: next-cycle implication failed");

`else

`define BSC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define BSC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define BSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* src/bsc_pkg.sv */
package bsc_pkg;

	// Port field widths.
	localparam int CAL_W     = 16;
	localparam int RAW_W     = 24;
	localparam int TEMP_W    = 16;
	localparam int PRES_W    = 18;
	localparam int CFG_IDX_W = 3;

	// Front datapath widths.
	localparam int DT_W  = 25;
	localparam int MUL_W = 42;
	localparam int DD_W  = 2 * DT_W;
	localparam int QT_W  = 18;
	localparam int QO_W  = 35;
	localparam int QS_W  = 34;
	localparam int T1_W  = 19;
	localparam int T2_W  = 17;
	localparam int OFF_W = 42;
	localparam int SENS_W = 40;

	// Back datapath widths.
	localparam int SQA_W   = 34;
	localparam int SQB_W   = 35;
	localparam int MA_W    = 40;
	localparam int MB_W    = 39;
	localparam int OFF2_W  = 40;
	localparam int SENS2_W = 39;
	localparam int TF_W    = 20;
	localparam int SPLIT_W = 20;
	localparam int PL_W    = RAW_W + SPLIT_W;
	localparam int PH_W    = RAW_W + 1 + SENS_W - SPLIT_W;
	localparam int PROD_W  = 64;
	localparam int PQ_W    = 43;
	localparam int NUM_W   = 44;

	// Scaling shifts.
	localparam int REF_SHIFT      = 8;
	localparam int TEMP_SHIFT     = 23;
	localparam int OFF_SHIFT      = 6;
	localparam int SENS_SHIFT     = 7;
	localparam int T2_SHIFT       = 31;
	localparam int OFF_CAL_SHIFT  = 17;
	localparam int SENS_CAL_SHIFT = 16;
	localparam int OFF2_SHIFT     = 4;
	localparam int SENS2_SHIFT    = 1;
	localparam int SENS2_COLD_SHIFT = 3;
	localparam int P_SHIFT        = 21;
	localparam int P_OUT_SHIFT    = 15;

	// Correction constants.
	localparam int TEMP_BASE      = 2000;
	localparam int COLD_OFS       = 3500;
	localparam int OFF2_GAIN      = 61;
	localparam int OFF2_COLD_GAIN = 15;
	localparam int TEMP_MAX       = 32767;
	localparam int TEMP_MIN       = -32768;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CAL_SENS_GAIN   = 3'd0,
		CAL_OFFSET      = 3'd1,
		CAL_SENS_TC     = 3'd2,
		CAL_OFFSET_TC   = 3'd3,
		CAL_REF_TEMP    = 3'd4,
		CAL_TEMP_COEFF  = 3'd5
	} cal_idx_t;

	typedef struct packed {
		logic [CAL_W-1:0] sens_gain_cal;
		logic [CAL_W-1:0] offset_cal;
		logic [CAL_W-1:0] sens_temp_coeff;
		logic [CAL_W-1:0] offset_temp_coeff;
		logic [CAL_W-1:0] ref_temperature;
		logic [CAL_W-1:0] temp_coeff;
	} cal_t;

	// One classified item handed from the front to the back.
	typedef struct packed {
		logic [RAW_W-1:0]         d1;
		logic signed [T1_W-1:0]   temp1;
		logic signed [OFF_W-1:0]  off1;
		logic signed [SENS_W-1:0] sens1;
		logic [T2_W-1:0]          t2;
		logic signed [QT_W-1:0]   dev;
		logic signed [T1_W-1:0]   dev_cold;
		logic                     low;
		logic                     cold;
	} comp_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* src/bsc_if.sv */
interface bsc_in_if;
	logic                       valid;
	logic                       ready;
	logic [bsc_pkg::RAW_W-1:0]  raw_pressure;
	logic [bsc_pkg::RAW_W-1:0]  raw_temp;
	modport source(output valid, raw_pressure, raw_temp, input ready);
	modport sink(input valid, raw_pressure, raw_temp, output ready);
endinterface

interface bsc_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [bsc_pkg::TEMP_W-1:0] temperature;
	logic [bsc_pkg::PRES_W-1:0]        pressure_pa;
	modport source(output valid, temperature, pressure_pa, input ready);
	modport sink(input valid, temperature, pressure_pa, output ready);
endinterface

interface bsc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bsc_pkg::CFG_IDX_W-1:0] index;
	logic [bsc_pkg::CAL_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* src/baro_sensor_compensation.sv */
// Channel  | Direction | Beat contents
// ---------+-----------+-------------------------------------------------
// cfg      | in        | index (register 0..5), data (16-bit word)
// sample   | in        | raw_pressure, raw_temp (24 bits each)
// result   | out       | temperature (signed 0.01 C), pressure_pa (18 bits)
//
// One sample beat can be taken every cycle unless the front stalls; each result passes
// through 4 front stages, the queue, and 8 back stages with the output register.
// The front stalls only when the four-entry queue is full; the back stalls as a
// whole while a result waits in the output register.
// Reset clears valid bits, queue pointers and the calibration words to zero.
// cfg is always ready; writes to an index above five are dropped.
`include "baro_sensor_compensation_assert.svh"

module baro_sensor_compensation (
	input logic        clk,
	input logic        arst_n,
	bsc_cfg_if.sink    cfg,
	bsc_in_if.sink     sample,
	bsc_out_if.source  result
);

	bsc_pkg::cal_t        cal_q;
	logic                 push;
	logic                 pop;
	bsc_pkg::comp_item_t  push_item;
	bsc_pkg::comp_item_t  head;
	bsc_pkg::q_stat_t     q_stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg.valid) begin
			unique case (bsc_pkg::cal_idx_t'(cfg.index))
				bsc_pkg::CAL_SENS_GAIN:  cal_q.sens_gain_cal     <= cfg.data;
				bsc_pkg::CAL_OFFSET:     cal_q.offset_cal        <= cfg.data;
				bsc_pkg::CAL_SENS_TC:    cal_q.sens_temp_coeff   <= cfg.data;
				bsc_pkg::CAL_OFFSET_TC:  cal_q.offset_temp_coeff <= cfg.data;
				bsc_pkg::CAL_REF_TEMP:   cal_q.ref_temperature   <= cfg.data;
				bsc_pkg::CAL_TEMP_COEFF: cal_q.temp_coeff        <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	bsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cal       (cal_q),
		.sample    (sample),
		.q_full    (q_stat.full),
		.push      (push),
		.push_item (push_item)
	);

	bsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	bsc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_stat.empty),
		.head    (head),
		.pop     (pop),
		.result  (result)
	);

	`BSC_ASSERT_NEVER(a_push_when_full, clk, arst_n, push && q_stat.full)
	`BSC_ASSERT_NEVER(a_pop_when_empty, clk, arst_n, pop && q_stat.empty)
	`BSC_ASSERT_IMPLY(a_stall_only_on_full, clk, arst_n, !sample.ready, q_stat.full)
	`BSC_ASSERT_NEXT(a_push_fills, clk, arst_n, push && !pop, !q_stat.empty)

endmodule

/* src/bsc_front.sv */
module bsc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bsc_pkg::cal_t        cal,
	bsc_in_if.sink               sample,
	input  logic                 q_full,
	output logic                 push,
	output bsc_pkg::comp_item_t  push_item
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [bsc_pkg::RAW_W-1:0]          d1_s1, d1_s2, d1_s3;
	logic signed [bsc_pkg::DT_W-1:0]    dt_s1;
	logic signed [bsc_pkg::MUL_W-1:0]   pt_s2, po_s2, ps_s2;
	logic signed [bsc_pkg::DD_W-1:0]    dd_s2;
	logic signed [bsc_pkg::QT_W-1:0]    qt_s3;
	logic signed [bsc_pkg::QO_W-1:0]    qo_s3;
	logic signed [bsc_pkg::QS_W-1:0]    qs_s3;
	logic [bsc_pkg::T2_W-1:0]           t2_s3;
	bsc_pkg::comp_item_t                item_s4;

	logic signed [bsc_pkg::DT_W-1:0]    dt_c;
	logic [bsc_pkg::MUL_W-1:0]          pt_b, po_b, ps_b;
	logic signed [bsc_pkg::T1_W-1:0]    dev_cold_c;

	// The whole front moves together; it only waits for room in the queue.
	assign en           = !(v_s4 && q_full);
	assign sample.ready = en;
	assign push         = v_s4 && !q_full;
	assign push_item    = item_s4;

	assign dt_c = $signed({1'b0, sample.raw_temp})
		- $signed({1'b0, cal.ref_temperature, {bsc_pkg::REF_SHIFT{1'b0}}});

	// Signed division by a power of two, truncating toward zero: bias negatives first.
	assign pt_b = pt_s2 + {{(bsc_pkg::MUL_W - bsc_pkg::TEMP_SHIFT){1'b0}},
		{bsc_pkg::TEMP_SHIFT{pt_s2[bsc_pkg::MUL_W-1]}}};
	assign po_b = po_s2 + {{(bsc_pkg::MUL_W - bsc_pkg::OFF_SHIFT){1'b0}},
		{bsc_pkg::OFF_SHIFT{po_s2[bsc_pkg::MUL_W-1]}}};
	assign ps_b = ps_s2 + {{(bsc_pkg::MUL_W - bsc_pkg::SENS_SHIFT){1'b0}},
		{bsc_pkg::SENS_SHIFT{ps_s2[bsc_pkg::MUL_W-1]}}};

	assign dev_cold_c = bsc_pkg::T1_W'(qt_s3) + bsc_pkg::T1_W'(bsc_pkg::COLD_OFS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1 <= sample.raw_pressure;
			dt_s1 <= dt_c;

			d1_s2 <= d1_s1;
			pt_s2 <= dt_s1 * $signed({1'b0, cal.temp_coeff});
			po_s2 <= dt_s1 * $signed({1'b0, cal.offset_temp_coeff});
			ps_s2 <= dt_s1 * $signed({1'b0, cal.sens_temp_coeff});
			dd_s2 <= dt_s1 * dt_s1;

			d1_s3 <= d1_s2;
			qt_s3 <= pt_b[bsc_pkg::TEMP_SHIFT + bsc_pkg::QT_W - 1:bsc_pkg::TEMP_SHIFT];
			qo_s3 <= po_b[bsc_pkg::OFF_SHIFT + bsc_pkg::QO_W - 1:bsc_pkg::OFF_SHIFT];
			qs_s3 <= ps_b[bsc_pkg::SENS_SHIFT + bsc_pkg::QS_W - 1:bsc_pkg::SENS_SHIFT];
			t2_s3 <= dd_s2[bsc_pkg::T2_SHIFT + bsc_pkg::T2_W - 1:bsc_pkg::T2_SHIFT];

			item_s4.d1    <= d1_s3;
			item_s4.temp1 <= bsc_pkg::T1_W'(qt_s3) + bsc_pkg::T1_W'(bsc_pkg::TEMP_BASE);
			item_s4.off1  <= $signed({{(bsc_pkg::OFF_W - bsc_pkg::CAL_W
				- bsc_pkg::OFF_CAL_SHIFT){1'b0}}, cal.offset_cal,
				{bsc_pkg::OFF_CAL_SHIFT{1'b0}}}) + bsc_pkg::OFF_W'(qo_s3);
			item_s4.sens1 <= $signed({{(bsc_pkg::SENS_W - bsc_pkg::CAL_W
				- bsc_pkg::SENS_CAL_SHIFT){1'b0}}, cal.sens_gain_cal,
				{bsc_pkg::SENS_CAL_SHIFT{1'b0}}}) + bsc_pkg::SENS_W'(qs_s3);
			item_s4.t2    <= t2_s3;
			// The first-order temperature sits below 20.00 C exactly when its
			// deviation is negative, and below -15.00 C when the cold term is.
			item_s4.dev      <= qt_s3;
			item_s4.dev_cold <= dev_cold_c;
			item_s4.low      <= qt_s3[bsc_pkg::QT_W-1];
			item_s4.cold     <= dev_cold_c[bsc_pkg::T1_W-1];
		end
	end

endmodule

/* src/bsc_queue.sv */
module bsc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bsc_pkg::comp_item_t  push_item,
	input  logic                 pop,
	output bsc_pkg::comp_item_t  head,
	output bsc_pkg::q_stat_t     stat
);

	bsc_pkg::comp_item_t              entries_q [bsc_pkg::QUEUE_DEPTH];
	logic [bsc_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [bsc_pkg::QCNT_W-1:0]       count_q;

	assign head       = entries_q[rd_ptr_q];
	assign stat.full  = (count_q == bsc_pkg::QCNT_W'(bsc_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == bsc_pkg::QPTR_W'(bsc_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (rd_ptr_q == bsc_pkg::QPTR_W'(bsc_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* src/bsc_back.sv */
module bsc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  bsc_pkg::comp_item_t  head,
	output logic                 pop,
	bsc_out_if.source            result
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic res_valid_q;
	logic signed [bsc_pkg::TEMP_W-1:0] res_temp_q;
	logic [bsc_pkg::PRES_W-1:0]        res_pres_q;

	bsc_pkg::comp_item_t item_s1, item_s2, item_s3;
	logic [bsc_pkg::SQA_W-1:0]    sqa_s1, sqa_s2;
	logic [bsc_pkg::SQB_W-1:0]    sqb_s1, sqb_s2;
	logic [bsc_pkg::MA_W-1:0]     ma_s2;
	logic [bsc_pkg::MB_W-1:0]     mb_s2;
	logic [bsc_pkg::OFF2_W-1:0]   off2_s3;
	logic [bsc_pkg::SENS2_W-1:0]  sens2_s3;
	logic signed [bsc_pkg::TF_W-1:0] temp_f_s3;

	logic [bsc_pkg::RAW_W-1:0]          d1_s4;
	logic signed [bsc_pkg::OFF_W-1:0]   off_s4, off_s5, off_s6, off_s7;
	logic signed [bsc_pkg::SENS_W-1:0]  sens_s4;
	logic signed [bsc_pkg::TEMP_W-1:0]  temp_s4, temp_s5, temp_s6, temp_s7;
	logic [bsc_pkg::PL_W-1:0]           pl_s5;
	logic signed [bsc_pkg::PH_W-1:0]    ph_s5;
	logic signed [bsc_pkg::PROD_W-1:0]  prod_s6;
	logic signed [bsc_pkg::PQ_W-1:0]    pq_s7;

	logic signed [2*bsc_pkg::QT_W-1:0]  sqa_c;
	logic signed [2*bsc_pkg::T1_W-1:0]  sqb_c;
	logic signed [bsc_pkg::TEMP_W-1:0]  temp_sat_c;
	logic [bsc_pkg::PROD_W-1:0]         prod_b;
	logic signed [bsc_pkg::NUM_W-1:0]   num_c;
	logic [bsc_pkg::PRES_W-1:0]         pres_c;

	// All stages advance together whenever the output register can take a beat.
	assign en  = !(res_valid_q && !result.ready);
	assign pop = en && !q_empty;

	assign result.valid       = res_valid_q;
	assign result.temperature = res_temp_q;
	assign result.pressure_pa = res_pres_q;

	assign sqa_c = head.dev * head.dev;
	assign sqb_c = head.dev_cold * head.dev_cold;

	always_comb begin
		if (temp_f_s3 > bsc_pkg::TF_W'(bsc_pkg::TEMP_MAX)) begin
			temp_sat_c = bsc_pkg::TEMP_W'(bsc_pkg::TEMP_MAX);
		end else if (temp_f_s3 < bsc_pkg::TF_W'(bsc_pkg::TEMP_MIN)) begin
			temp_sat_c = bsc_pkg::TEMP_W'(bsc_pkg::TEMP_MIN);
		end else begin
			temp_sat_c = temp_f_s3[bsc_pkg::TEMP_W-1:0];
		end
	end

	// Truncating division of the product: bias negatives before the shift.
	assign prod_b = prod_s6 + {{(bsc_pkg::PROD_W - bsc_pkg::P_SHIFT){1'b0}},
		{bsc_pkg::P_SHIFT{prod_s6[bsc_pkg::PROD_W-1]}}};

	assign num_c = bsc_pkg::NUM_W'(pq_s7) - bsc_pkg::NUM_W'(off_s7);

	// A negative numerator gives zero whether the final shift floors or truncates.
	always_comb begin
		if (num_c[bsc_pkg::NUM_W-1]) begin
			pres_c = '0;
		end else if (|num_c[bsc_pkg::NUM_W-2:bsc_pkg::P_OUT_SHIFT + bsc_pkg::PRES_W]) begin
			pres_c = '1;
		end else begin
			pres_c = num_c[bsc_pkg::P_OUT_SHIFT + bsc_pkg::PRES_W - 1:bsc_pkg::P_OUT_SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			res_valid_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= head;
			sqa_s1  <= sqa_c[bsc_pkg::SQA_W-1:0];
			sqb_s1  <= sqb_c[bsc_pkg::SQB_W-1:0];

			item_s2 <= item_s1;
			sqa_s2  <= sqa_s1;
			sqb_s2  <= sqb_s1;
			ma_s2   <= bsc_pkg::MA_W'(sqa_s1) * bsc_pkg::MA_W'(bsc_pkg::OFF2_GAIN);
			mb_s2   <= bsc_pkg::MB_W'(sqb_s1) * bsc_pkg::MB_W'(bsc_pkg::OFF2_COLD_GAIN);

			item_s3  <= item_s2;
			off2_s3  <= bsc_pkg::OFF2_W'(ma_s2 >> bsc_pkg::OFF2_SHIFT)
				+ (item_s2.cold ? bsc_pkg::OFF2_W'(mb_s2) : '0);
			sens2_s3 <= bsc_pkg::SENS2_W'({sqa_s2, {bsc_pkg::SENS2_SHIFT{1'b0}}})
				+ (item_s2.cold
					? bsc_pkg::SENS2_W'({sqb_s2, {bsc_pkg::SENS2_COLD_SHIFT{1'b0}}})
					: '0);
			temp_f_s3 <= bsc_pkg::TF_W'(item_s2.temp1)
				- (item_s2.low ? bsc_pkg::TF_W'(item_s2.t2) : '0);

			d1_s4   <= item_s3.d1;
			off_s4  <= item_s3.off1
				- (item_s3.low ? bsc_pkg::OFF_W'(off2_s3) : '0);
			sens_s4 <= item_s3.sens1
				- (item_s3.low ? bsc_pkg::SENS_W'(sens2_s3) : '0);
			temp_s4 <= temp_sat_c;

			// The wide product is split into two partial products.
			pl_s5   <= bsc_pkg::PL_W'(d1_s4) * bsc_pkg::PL_W'(sens_s4[bsc_pkg::SPLIT_W-1:0]);
			ph_s5   <= bsc_pkg::PH_W'($signed({1'b0, d1_s4}))
				* bsc_pkg::PH_W'($signed(sens_s4[bsc_pkg::SENS_W-1:bsc_pkg::SPLIT_W]));
			off_s5  <= off_s4;
			temp_s5 <= temp_s4;

			prod_s6 <= (bsc_pkg::PROD_W'(ph_s5) <<< bsc_pkg::SPLIT_W)
				+ $signed(bsc_pkg::PROD_W'(pl_s5));
			off_s6  <= off_s5;
			temp_s6 <= temp_s5;

			pq_s7   <= prod_b[bsc_pkg::P_SHIFT + bsc_pkg::PQ_W - 1:bsc_pkg::P_SHIFT];
			off_s7  <= off_s6;
			temp_s7 <= temp_s6;

			res_temp_q <= temp_s7;
			res_pres_q <= pres_c;
		end
	end

endmodule
